### sv/pmrng_pkg.sv
`default_nettype none
package pmrng_pkg;

  localparam int unsigned SEED_W      = 31;
  localparam int unsigned HASH_W      = 32;
  localparam int unsigned MULT_W      = 15;
  localparam int unsigned PROD_W      = SEED_W + MULT_W;
  localparam int unsigned HASH_BYTES  = 28;
  localparam int unsigned MASK_W      = 27;
  localparam int unsigned WARMUP      = 5;
  localparam int unsigned CNT_W       = 5;

  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [SEED_W:0]   LCG_MOD  = 32'd2147483647;

  typedef logic [1:0] hop_t;
  localparam hop_t HOP_BYTE  = 2'd0;
  localparam hop_t HOP_MIX3  = 2'd1;
  localparam hop_t HOP_MIX11 = 2'd2;
  localparam hop_t HOP_MIX15 = 2'd3;

  typedef struct packed {
    logic clr;
    logic en;
    hop_t op;
  } hash_ctl_t;

endpackage
`default_nettype wire

### sv/pmrng_if.sv
`default_nettype none
interface pmrng_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] base_value;
  logic        [63:0] coord_x;
  logic        [63:0] coord_y;
  logic        [63:0] coord_z;

  modport source (output valid, op, base_value, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, op, base_value, coord_x, coord_y, coord_z, output ready);
endinterface

interface pmrng_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink (input valid, random_value, output ready);
endinterface
`default_nettype wire

### sv/pmrng_lcg.sv
`default_nettype none
module pmrng_lcg
  import pmrng_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [SEED_W-1:0] seed_in,
  output logic      [SEED_W-1:0] seed_out
);

  logic [PROD_W-1:0] prod_r;
  logic [SEED_W:0]   sum;
  logic [SEED_W:0]   red;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(seed_in) * PROD_W'(LCG_MULT);
    end
  end

  always_comb begin
    sum = {1'b0, prod_r[SEED_W-1:0]} + (SEED_W+1)'(prod_r[PROD_W-1:SEED_W]);
    red = (sum >= LCG_MOD) ? (sum - LCG_MOD) : sum;
    seed_out = red[SEED_W-1:0];
  end

endmodule
`default_nettype wire

### sv/pmrng_hash.sv
`default_nettype none
module pmrng_hash
  import pmrng_pkg::*;
(
  input  wire logic              clk,
  input  wire hash_ctl_t         ctl,
  input  wire logic [7:0]        byte_in,
  output logic      [HASH_W-1:0] hash_out
);

  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] h_nxt;
  logic [HASH_W-1:0] t1;
  logic [HASH_W-1:0] t2;

  always_comb begin
    t1 = h_r + {{(HASH_W-8){byte_in[7]}}, byte_in};
    t2 = t1 + (t1 << 10);
    case (ctl.op)
      HOP_BYTE:  h_nxt = t2 ^ (t2 >> 6);
      HOP_MIX3:  h_nxt = h_r + (h_r << 3);
      HOP_MIX11: h_nxt = h_r ^ (h_r >> 11);
      HOP_MIX15: h_nxt = h_r + (h_r << 15);
      default:   h_nxt = h_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      h_r <= '0;
    end else if (ctl.en) begin
      h_r <= h_nxt;
    end
  end

  assign hash_out = h_r;

endmodule
`default_nettype wire

### sv/park_miller_rng_with_hash_reseed.sv
// Draw request: a multiply step and a reduce step in the shared modular multiplier, then
// the output load; no new request is taken until the result has been loaded.
// Reseed request: 28 hash byte steps, 3 mix steps, 1 seed load, 5 draws (multiply, reduce)
// and the output load; no new request is taken until the result has been loaded.
// Input ready stays low while a finished result waits for the output register.
// Synchronous active-low reset returns the seed to 1 and empties the output.
`default_nettype none
module park_miller_rng_with_hash_reseed
  import pmrng_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pmrng_in_if.sink    in_ch,
  pmrng_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HASH = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_RED  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int unsigned BYTES_W = HASH_BYTES * 8;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [SEED_W-1:0]  seed_r;
  logic [SEED_W-1:0]  seed_nxt;
  logic [BYTES_W-1:0] bytes_r;
  logic [BYTES_W-1:0] bytes_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [SEED_W-1:0]  out_data_r;
  logic [SEED_W-1:0]  out_data_nxt;

  hash_ctl_t         hctl;
  logic [HASH_W-1:0] hash_val;
  logic [SEED_W-1:0] lcg_val;
  logic              accept;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_data_r;

  pmrng_hash u_hash (
    .clk      (clk),
    .ctl      (hctl),
    .byte_in  (bytes_r[7:0]),
    .hash_out (hash_val)
  );

  pmrng_lcg u_lcg (
    .clk      (clk),
    .load     (state_r == ST_MUL),
    .seed_in  (seed_r),
    .seed_out (lcg_val)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seed_nxt      = seed_r;
    bytes_nxt     = bytes_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    hctl          = '{clr: 1'b0, en: 1'b0, op: HOP_BYTE};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_ch.op) begin
            bytes_nxt = {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x, in_ch.base_value};
            hctl.clr  = 1'b1;
            state_nxt = ST_HASH;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_HASH: begin
        hctl.en   = 1'b1;
        hctl.op   = HOP_BYTE;
        bytes_nxt = bytes_r >> 8;
        if (cnt_r == CNT_W'(HASH_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        hctl.en = 1'b1;
        case (cnt_r[1:0])
          2'd0:    hctl.op = HOP_MIX3;
          2'd1:    hctl.op = HOP_MIX11;
          default: hctl.op = HOP_MIX15;
        endcase
        if (cnt_r[1:0] == 2'd2) begin
          state_nxt = ST_LOAD;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_LOAD: begin
        seed_nxt = (hash_val[MASK_W-1:0] == '0) ? SEED_W'(1)
                                                : SEED_W'(hash_val[MASK_W-1:0]);
        cnt_nxt   = CNT_W'(WARMUP - 1);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        seed_nxt = lcg_val;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = seed_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seed_r      <= SEED_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

### bench/pmrng_checker.sv
`default_nettype none
module pmrng_checker
  import pmrng_pkg::*;
#(
  parameter logic OP_RESEED = 1'b1
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pmrng_in_if         in_mon,
  pmrng_out_if        out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SEED_W-1:0] seed_model;
  logic [SEED_W-1:0] seed_q[$];
  logic [SEED_W-1:0] want;

  function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] s);
    logic [63:0] prod;
    prod = 64'(s) * 64'(LCG_MULT);
    return SEED_W'(prod % 64'(LCG_MOD));
  endfunction

  function automatic logic [SEED_W-1:0] reseed_seed(input logic [31:0] base,
                                                    input logic [63:0] x,
                                                    input logic [63:0] y,
                                                    input logic [63:0] z);
    logic [8*HASH_BYTES-1:0] msg;
    logic [31:0]             h;
    logic [SEED_W-1:0]       s;
    msg = {z, y, x, base};
    h   = '0;
    for (int i = 0; i < HASH_BYTES; i++) begin
      h = h + {{24{msg[8*i+7]}}, msg[8*i +: 8]};
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    s = SEED_W'(h[MASK_W-1:0]);
    if (s == '0) begin
      s = SEED_W'(1);
    end
    repeat (WARMUP) s = lcg_next(s);
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_model = SEED_W'(1);
      seed_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_RESEED) begin
          seed_model = reseed_seed(in_mon.base_value, in_mon.coord_x, in_mon.coord_y,
                                   in_mon.coord_z);
        end else begin
          seed_model = lcg_next(seed_model);
        end
        seed_q.push_back(seed_model);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (seed_q.size() == 0) begin
          $display("%0t: unexpected random_value, expected none, got %0d",
                   $time, out_mon.random_value);
          fail_count <= fail_count + 1;
        end else begin
          want = seed_q.pop_front();
          if (out_mon.random_value !== want) begin
            $display("%0t: random_value mismatch, expected %0d, got %0d",
                     $time, want, out_mon.random_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= seed_q.size();
    end
  end

endmodule
`default_nettype wire

### bench/tb_park_miller_rng_with_hash_reseed.sv
`default_nettype none
module tb_park_miller_rng_with_hash_reseed;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n;
  int          in_idle_pct;
  int          out_idle_pct;
  int unsigned fail_count;
  int unsigned pending;

  logic [15:0] tail_of[logic [31:0]];

  pmrng_in_if  in_ch();
  pmrng_out_if out_ch();

  park_miller_rng_with_hash_reseed u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pmrng_checker #(.OP_RESEED(OP_RESEED)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {{24{b[7]}}, b};
    t = t + (t << 10);
    return t ^ (t >> 6);
  endfunction

  function automatic logic [31:0] undo_xorshr(input logic [31:0] y, input int sh);
    logic [31:0] r;
    r = y;
    for (int i = 0; i < 32; i += sh) r = y ^ (r >> sh);
    return r;
  endfunction

  function automatic logic [31:0] undo_addshl(input logic [31:0] y, input int sh);
    logic [31:0] r;
    r = y;
    for (int i = 0; i < 32; i += sh) r = y - (r << sh);
    return r;
  endfunction

  function automatic logic [31:0] undo_fold(input logic [31:0] y, input logic [7:0] b);
    return undo_addshl(undo_xorshr(y, 6), 10) - {{24{b[7]}}, b};
  endfunction

  function automatic logic [63:0] rand_word64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_req(input logic op, input logic [31:0] base, input logic [63:0] x,
                          input logic [63:0] y, input logic [63:0] z);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.base_value <= base;
    in_ch.coord_x    <= x;
    in_ch.coord_y    <= y;
    in_ch.coord_z    <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int in_pct, input int out_pct);
    logic op;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < 12) ? OP_RESEED : OP_DRAW;
      send_req(op, $urandom, rand_word64(), rand_word64(), rand_word64());
      if (i == n / 2) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [31:0] pre;
    logic [31:0] v;
    logic [31:0] w;
    logic [63:0] z_zero;
    logic        found;
    in_idle_pct      = 0;
    out_idle_pct     = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_DRAW;
    in_ch.base_value <= '0;
    in_ch.coord_x    <= '0;
    in_ch.coord_y    <= '0;
    in_ch.coord_z    <= '0;

    // find a z whose upper bytes drive the masked hash to zero, all other bytes zero
    found  = 1'b0;
    z_zero = '0;
    for (int b25 = 0; b25 < 256; b25++) begin
      for (int b26 = 0; b26 < 256; b26++) begin
        tail_of[fold_byte(fold_byte('0, 8'(b25)), 8'(b26))] = {8'(b26), 8'(b25)};
      end
    end
    for (int top = 0; top < 32 && !found; top++) begin
      pre = undo_addshl(undo_xorshr(undo_addshl({5'(top), 27'd0}, 15), 11), 3);
      for (int b28 = 0; b28 < 256 && !found; b28++) begin
        v = undo_fold(pre, 8'(b28));
        for (int b27 = 0; b27 < 256 && !found; b27++) begin
          w = undo_fold(v, 8'(b27));
          if (tail_of.exists(w)) begin
            z_zero = {8'(b28), 8'(b27), tail_of[w], 32'd0};
            found  = 1'b1;
          end
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(OP_DRAW, '0, '0, '0, '0);
    send_req(OP_DRAW, '1, '1, '1, '1);
    send_req(OP_RESEED, '0, '0, '0, '0);
    send_req(OP_DRAW, '0, '0, '0, '0);
    send_req(OP_RESEED, '1, '1, '1, '1);
    send_req(OP_RESEED, 32'h8000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
             64'h8000_0000_0000_0000);
    send_req(OP_RESEED, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
             64'h7fff_ffff_ffff_ffff);
    send_req(OP_RESEED, 32'h8080_8080, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
             64'h8080_8080_8080_8080);
    send_req(OP_RESEED, 32'h7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f,
             64'h7f7f_7f7f_7f7f_7f7f);
    send_req(OP_RESEED, 32'h0000_0001, 64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000,
             64'h7ff0_0000_0000_0000);
    send_req(OP_RESEED, '0, '0, '0, z_zero);
    send_req(OP_DRAW, $urandom, '1, '0, '1);
    send_req(OP_DRAW, $urandom, '0, '1, '0);
    send_req(OP_RESEED, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom});
    repeat (4) send_req(OP_DRAW, '0, '0, '0, '0);
    wait_drained();

    run_phase(450, 16, 51);
    run_phase(450, 51, 16);
    run_phase(450, 0, 0);

    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
